// ----- rtl/va3_pkg.sv -----
// shared constants, types and arctangent table functions for the vector angle block
package va3_pkg;

  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int MIN_NORM_W    = 16;
  localparam int ROOT_BITS     = 60;
  localparam int WIDE_W        = 120;
  localparam int CORDIC_STEPS  = 60;
  localparam int TH_W          = 64;
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_NORM = 2'd0,
    REG_UNIT_DEG = 2'd1
  } va3_reg_t;

  typedef struct packed {
    logic inv;
    logic zero;
  } va3_flags_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] atan_series(input logic [63:0] r);
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] acc;
    q   = udiv64(64'd1 << 60, r);
    acc = '0;
    for (int n = 0; n < 64; n++) begin
      if (q != 64'd0) begin
        t = udiv64(q, 64'(2 * n + 1));
        if ((n & 1) == 1) acc = acc - t;
        else acc = acc + t;
        q = udiv64(udiv64(q, r), r);
      end
    end
    return acc;
  endfunction

  // atan(2^-i) in q60 radians
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] v;
    if (i == 0) v = atan_series(64'd2) + atan_series(64'd3);
    else v = atan_series(64'd1 << i);
    return v;
  endfunction

  localparam logic [63:0] ATAN_0  = atan_entry(0);
  localparam logic [63:0] HALF_PI = ATAN_0 << 1;
  localparam logic [63:0] PI_Q60  = ATAN_0 << 2;

endpackage

// ----- rtl/va3_front.sv -----
// front part: input register, component products, norms, dot product and classification
module va3_front import va3_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_a_x,
  input  logic signed [SAMPLE_BITS-1:0] in_a_y,
  input  logic signed [SAMPLE_BITS-1:0] in_a_z,
  input  logic signed [SAMPLE_BITS-1:0] in_b_x,
  input  logic signed [SAMPLE_BITS-1:0] in_b_y,
  input  logic signed [SAMPLE_BITS-1:0] in_b_z,
  input  logic [2*MIN_NORM_W-1:0]       lim,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [2*SAMPLE_BITS-1:0]      q_na2,
  output logic [2*SAMPLE_BITS-1:0]      q_nb2,
  output logic signed [2*SAMPLE_BITS:0] q_d,
  output va3_flags_t                    q_flags
);

  localparam int NW = 2 * SAMPLE_BITS;
  localparam int DW = NW + 1;
  localparam int CW = (NW > 2 * MIN_NORM_W) ? NW : 2 * MIN_NORM_W;

  logic [2:0] vld_r;
  logic fadv;
  logic signed [SAMPLE_BITS-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [NW-1:0] axx_r, ayy_r, azz_r, bxx_r, byy_r, bzz_r, dx_r, dy_r, dz_r;
  logic [NW-1:0] na2_r, nb2_r, na2_nxt, nb2_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  va3_flags_t flg_r, flg_nxt;

  assign fadv     = !vld_r[2] || !q_full;
  assign in_stall = !fadv;
  assign q_push   = vld_r[2] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fadv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_comb begin
    na2_nxt = $unsigned(axx_r) + $unsigned(ayy_r) + $unsigned(azz_r);
    nb2_nxt = $unsigned(bxx_r) + $unsigned(byy_r) + $unsigned(bzz_r);
    d_nxt   = DW'(dx_r) + DW'(dy_r) + DW'(dz_r);
    flg_nxt.inv  = (CW'(na2_nxt) < CW'(lim)) || (CW'(nb2_nxt) < CW'(lim));
    flg_nxt.zero = (na2_nxt == '0) || (nb2_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      ax_r  <= in_a_x;
      ay_r  <= in_a_y;
      az_r  <= in_a_z;
      bx_r  <= in_b_x;
      by_r  <= in_b_y;
      bz_r  <= in_b_z;
      axx_r <= ax_r * ax_r;
      ayy_r <= ay_r * ay_r;
      azz_r <= az_r * az_r;
      bxx_r <= bx_r * bx_r;
      byy_r <= by_r * by_r;
      bzz_r <= bz_r * bz_r;
      dx_r  <= ax_r * bx_r;
      dy_r  <= ay_r * by_r;
      dz_r  <= az_r * bz_r;
      na2_r <= na2_nxt;
      nb2_r <= nb2_nxt;
      d_r   <= d_nxt;
      flg_r <= flg_nxt;
    end
  end

  assign q_na2   = na2_r;
  assign q_nb2   = nb2_r;
  assign q_d     = d_r;
  assign q_flags = flg_r;

endmodule

// ----- rtl/va3_queue.sv -----
// short queue between the front and back parts
module va3_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign valid   = cnt_r != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop) rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end

endmodule

// ----- rtl/va3_back.sv -----
// back part: cross magnitude by exact square root, vectoring cordic, unit conversion
module va3_back import va3_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [2*SAMPLE_BITS-1:0]      q_na2,
  input  logic [2*SAMPLE_BITS-1:0]      q_nb2,
  input  logic signed [2*SAMPLE_BITS:0] q_d,
  input  va3_flags_t                    q_flags,
  input  logic                          unit_deg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_BITS-1:0]         out_angle,
  output logic                          out_invalid
);

  localparam int NW     = 2 * SAMPLE_BITS;
  localparam int PW     = 4 * SAMPLE_BITS;
  localparam int HW     = SAMPLE_BITS;
  localparam int PG     = (PW + 7) / 8;
  localparam int PPW    = PG * 8;
  localparam int LW     = $clog2(PPW + 1);
  localparam int KW     = $clog2(ROOT_BITS + 1);
  localparam int TW     = WIDE_W + 1;
  localparam int NB     = 6 + ROOT_BITS + CORDIC_STEPS + 3;
  localparam int SH_RAD = 62 - ANGLE_BITS;
  localparam int SH_DEG = 64 - ANGLE_BITS;
  localparam int RADW   = 64 - SH_RAD;
  localparam logic [RADW-1:0] ANG_MAX = RADW'((1 << ANGLE_BITS) - 1);

  logic adv;
  logic [NB-1:0] vld_r;
  va3_flags_t flg_r [NB];

  assign adv       = !vld_r[NB-1] || !out_stall;
  assign q_pop     = q_valid && adv;
  assign out_valid = vld_r[NB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NB-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_r[0] <= q_flags;
      for (int i = 1; i < NB; i++) flg_r[i] <= flg_r[i-1];
    end
  end

  // magnitude of the dot product
  logic [NW-1:0] dm1_r, na1_r, nb1_r;
  logic dneg1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dm1_r   <= q_d[NW] ? NW'(-q_d) : q_d[NW-1:0];
      dneg1_r <= q_d[NW];
      na1_r   <= q_na2;
      nb1_r   <= q_nb2;
    end
  end

  // split products for na2*nb2 and d^2
  logic [NW-1:0] pa_ll_r, pa_lh_r, pa_hl_r, pa_hh_r;
  logic [NW-1:0] pd_ll_r, pd_lh_r, pd_hl_r, pd_hh_r;
  logic [NW-1:0] dm2_r;
  logic dneg2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_ll_r <= na1_r[HW-1:0] * nb1_r[HW-1:0];
      pa_lh_r <= na1_r[HW-1:0] * nb1_r[NW-1:HW];
      pa_hl_r <= na1_r[NW-1:HW] * nb1_r[HW-1:0];
      pa_hh_r <= na1_r[NW-1:HW] * nb1_r[NW-1:HW];
      pd_ll_r <= dm1_r[HW-1:0] * dm1_r[HW-1:0];
      pd_lh_r <= dm1_r[HW-1:0] * dm1_r[NW-1:HW];
      pd_hl_r <= dm1_r[NW-1:HW] * dm1_r[HW-1:0];
      pd_hh_r <= dm1_r[NW-1:HW] * dm1_r[NW-1:HW];
      dm2_r   <= dm1_r;
      dneg2_r <= dneg1_r;
    end
  end

  logic [PW-1:0] p3_r, d23_r;
  logic [NW-1:0] dm3_r;
  logic dneg3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r  <= (PW'(pa_hh_r) << NW) + (PW'(pa_lh_r) << HW) + (PW'(pa_hl_r) << HW)
               + PW'(pa_ll_r);
      d23_r <= (PW'(pd_hh_r) << NW) + (PW'(pd_lh_r) << HW) + (PW'(pd_hl_r) << HW)
               + PW'(pd_ll_r);
      dm3_r   <= dm2_r;
      dneg3_r <= dneg2_r;
    end
  end

  // leading one of the norm product, per byte then across bytes
  logic [PPW-1:0] pp;
  logic [PG-1:0] nz_nxt, nz4_r;
  logic [2:0] pos_nxt [PG];
  logic [2:0] pos4_r [PG];
  logic [PW-1:0] x4_r;
  logic [NW-1:0] dm4_r;
  logic dneg4_r;

  always_comb begin
    pp = PPW'(p3_r);
    for (int g = 0; g < PG; g++) begin
      nz_nxt[g]  = |pp[g*8 +: 8];
      pos_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (pp[g*8 + b]) pos_nxt[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x4_r    <= p3_r - d23_r;
      nz4_r   <= nz_nxt;
      pos4_r  <= pos_nxt;
      dm4_r   <= dm3_r;
      dneg4_r <= dneg3_r;
    end
  end

  logic [LW-1:0] len;
  logic [7:0] klen;
  logic [KW-1:0] k5_r;
  logic [PW-1:0] x5_r;
  logic [NW-1:0] dm5_r;
  logic dneg5_r;

  always_comb begin
    len = '0;
    for (int g = 0; g < PG; g++) begin
      if (nz4_r[g]) len = LW'(g * 8) + LW'(pos4_r[g]) + LW'(1);
    end
    klen = 8'(WIDE_W) - 8'(len);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k5_r    <= klen[KW:1];
      x5_r    <= x4_r;
      dm5_r   <= dm4_r;
      dneg5_r <= dneg4_r;
    end
  end

  logic [WIDE_W-1:0] rad6_r;
  logic [ROOT_BITS-1:0] m6_r;
  logic dneg6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad6_r  <= WIDE_W'(x5_r) << {k5_r, 1'b0};
      m6_r    <= ROOT_BITS'(dm5_r) << k5_r;
      dneg6_r <= dneg5_r;
    end
  end

  // restoring square root, one result bit per stage
  logic [WIDE_W-1:0] sq_rem_w [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_root_w [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_m_w [ROOT_BITS+1];
  logic sq_neg_w [ROOT_BITS+1];

  assign sq_rem_w[0]  = rad6_r;
  assign sq_root_w[0] = '0;
  assign sq_m_w[0]    = m6_r;
  assign sq_neg_w[0]  = dneg6_r;

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sq
    localparam int B = ROOT_BITS - 1 - j;
    logic [TW-1:0] trial;
    logic take;
    logic [WIDE_W-1:0] rem_r;
    logic [ROOT_BITS-1:0] root_r, m_r;
    logic neg_r;

    always_comb begin
      trial = (TW'(sq_root_w[j]) << (B + 1)) | (TW'(1) << (2 * B));
      take  = trial <= {1'b0, sq_rem_w[j]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= take ? sq_rem_w[j] - trial[WIDE_W-1:0] : sq_rem_w[j];
        root_r <= take ? (sq_root_w[j] | (ROOT_BITS'(1) << B)) : sq_root_w[j];
        m_r    <= sq_m_w[j];
        neg_r  <= sq_neg_w[j];
      end
    end

    assign sq_rem_w[j+1]  = rem_r;
    assign sq_root_w[j+1] = root_r;
    assign sq_m_w[j+1]    = m_r;
    assign sq_neg_w[j+1]  = neg_r;
  end

  // vectoring cordic on (|d|, |a x b|), swapped and started at half pi when d is negative
  logic [TH_W-1:0] cx_w [CORDIC_STEPS+1];
  logic [TH_W-1:0] cy_w [CORDIC_STEPS+1];
  logic [TH_W-1:0] cz_w [CORDIC_STEPS+1];

  assign cx_w[0] = sq_neg_w[ROOT_BITS] ? TH_W'(sq_root_w[ROOT_BITS]) : TH_W'(sq_m_w[ROOT_BITS]);
  assign cy_w[0] = sq_neg_w[ROOT_BITS] ? TH_W'(sq_m_w[ROOT_BITS]) : TH_W'(sq_root_w[ROOT_BITS]);
  assign cz_w[0] = sq_neg_w[ROOT_BITS] ? HALF_PI : '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic [TH_W-1:0] T = atan_entry(i);
    logic [TH_W-1:0] xs, ys;
    logic [TH_W-1:0] x_r, y_r, z_r;

    always_comb begin
      xs = $signed(cx_w[i]) >>> i;
      ys = $signed(cy_w[i]) >>> i;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy_w[i][TH_W-1]) begin
          x_r <= cx_w[i] + ys;
          y_r <= cy_w[i] - xs;
          z_r <= cz_w[i] + T;
        end else begin
          x_r <= cx_w[i] - ys;
          y_r <= cy_w[i] + xs;
          z_r <= cz_w[i] - T;
        end
      end
    end

    assign cx_w[i+1] = x_r;
    assign cy_w[i+1] = y_r;
    assign cz_w[i+1] = z_r;
  end

  // clamp to [0, pi], then degree products
  logic [TH_W-1:0] th_r, th2_r, theta;
  logic [46:0] ph_r, pl_r;

  assign theta = cz_w[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      th_r  <= theta[TH_W-1] ? '0 : ((theta > PI_Q60) ? PI_Q60 : theta);
      th2_r <= th_r;
      ph_r  <= th_r[61:45] * DEG_PER_RAD_Q24;
      pl_r  <= th_r[44:28] * DEG_PER_RAD_Q24;
    end
  end

  logic [63:0] qd, qs, rs;
  logic [ANGLE_BITS-1:0] ang_deg, ang_rad;
  logic [RADW-1:0] rad_full;
  logic [ANGLE_BITS-1:0] out_angle_r;
  logic out_invalid_r;
  va3_flags_t fo;

  always_comb begin
    qd       = (64'(ph_r) << 17) + 64'(pl_r);
    qs       = qd + (64'(1) << (SH_DEG - 1));
    ang_deg  = qs[63:SH_DEG];
    rs       = th2_r + (64'(1) << (SH_RAD - 1));
    rad_full = rs[63:SH_RAD];
    ang_rad  = (rad_full > ANG_MAX) ? '1 : rad_full[ANGLE_BITS-1:0];
    fo       = flg_r[NB-2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_invalid_r <= fo.inv;
      out_angle_r   <= (fo.inv || fo.zero) ? '0 : (unit_deg ? ang_deg : ang_rad);
    end
  end

  assign out_angle   = out_angle_r;
  assign out_invalid = out_invalid_r;

endmodule

// ----- rtl/vector_angle_3d.sv -----
// top level of the angle between two signed 3d vectors
//
// Takes one vector pair per clock while in_stall is low and returns acos(a.b / (|a| |b|))
// one beat per pair, in order. Throughput is one beat per cycle while out_stall is low. A pair
// passes through the front registers, the four-entry queue and the back pipeline, which holds
// the 60-stage square root pipeline that forms |a x b| and the 60-stage vectoring cordic. With
// unit_degrees set the angle is unsigned degrees with ANGLE_BITS-8 fraction bits, otherwise radians
// with ANGLE_BITS-2 fraction bits. A vector whose norm is below min_norm gives invalid set and angle
// zero. Registers are to be written by the user only while no beat is in flight; the block does not enforce it.
module vector_angle_3d import va3_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_a_x,
  input  logic signed [SAMPLE_BITS-1:0] in_a_y,
  input  logic signed [SAMPLE_BITS-1:0] in_a_z,
  input  logic signed [SAMPLE_BITS-1:0] in_b_x,
  input  logic signed [SAMPLE_BITS-1:0] in_b_y,
  input  logic signed [SAMPLE_BITS-1:0] in_b_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_BITS-1:0]         out_angle,
  output logic                          out_invalid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int NW = 2 * SAMPLE_BITS;
  localparam int QW = 2 + (NW + 1) + 2 * NW;
  localparam logic [ANGLE_BITS-1:0] DEG_MAX = ANGLE_BITS'((180 << (ANGLE_BITS - 8)) + 1);

  logic [MIN_NORM_W-1:0] min_norm_r;
  logic unit_deg_r;
  logic [2*MIN_NORM_W-1:0] lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_r <= MIN_NORM_W'(1);
      unit_deg_r <= 1'b1;
      lim_r      <= (2*MIN_NORM_W)'(1);
    end else begin
      lim_r <= min_norm_r * min_norm_r;
      if (cfg_valid && cfg_ready) begin
        case (va3_reg_t'(cfg_index))
          REG_MIN_NORM: min_norm_r <= cfg_data[MIN_NORM_W-1:0];
          REG_UNIT_DEG: unit_deg_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  logic q_push, q_full, q_pop, q_valid;
  logic [NW-1:0] f_na2, f_nb2, b_na2, b_nb2;
  logic signed [NW:0] f_d, b_d;
  va3_flags_t f_flags, b_flags;
  logic [QW-1:0] q_wdata, q_rdata;

  va3_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_a_x   (in_a_x),
    .in_a_y   (in_a_y),
    .in_a_z   (in_a_z),
    .in_b_x   (in_b_x),
    .in_b_y   (in_b_y),
    .in_b_z   (in_b_z),
    .lim      (lim_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_na2    (f_na2),
    .q_nb2    (f_nb2),
    .q_d      (f_d),
    .q_flags  (f_flags)
  );

  assign q_wdata = {f_flags, f_d, f_nb2, f_na2};

  va3_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign b_na2   = q_rdata[NW-1:0];
  assign b_nb2   = q_rdata[2*NW-1:NW];
  assign b_d     = q_rdata[3*NW:2*NW];
  assign b_flags = q_rdata[QW-1:3*NW+1];

  va3_back #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_na2       (b_na2),
    .q_nb2       (b_nb2),
    .q_d         (b_d),
    .q_flags     (b_flags),
    .unit_deg    (unit_deg_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_angle   (out_angle),
    .out_invalid (out_invalid)
  );

  a_inv_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_angle == '0)
    else $error("invalid beat with nonzero angle");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue written while full");

  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unit_deg_r |-> out_angle <= DEG_MAX)
    else $error("degree angle beyond half turn");

endmodule

// ----- test/vector_angle_3d_test.sv -----
// self-checking testbench for the 3d vector angle block
module vector_angle_3d_test;
  import va3_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE = 160;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct packed {
    logic [15:0] angle;
    logic        invalid;
  } angle_res_t;

  typedef struct {
    pair_t      pair;
    logic [15:0] min_norm;
    logic        deg;
    bit          typed;
    angle_res_t  res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [15:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  logic [15:0] out_angle;
  logic out_invalid;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [63:0] arctan_q60 [60];
  logic [15:0] cur_min_norm;
  logic        cur_deg;
  bit          quiet;
  angle_res_t  angles_due[$];
  row_t        rows[$];
  int          errors;
  int          idle_cycles;

  vector_angle_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_angle(out_angle), .out_invalid(out_invalid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] arctan_recip(input logic [63:0] r);
    logic [63:0] q, acc;
    int n;
    q = (64'd1 << 60) / r;
    acc = '0;
    n = 0;
    while (q != 0) begin
      if (n % 2 == 1) acc = acc - q / (2 * n + 1);
      else acc = acc + q / (2 * n + 1);
      q = q / r / r;
      n++;
    end
    return acc;
  endfunction

  function automatic angle_res_t predict_angle(input pair_t p, input logic [15:0] mn,
                                               input logic deg);
    longint na2, nb2, d;
    logic [63:0] dm, s, m, z, base, theta, q, ang, c, lim;
    logic signed [63:0] x, y, xs, ys;
    logic [127:0] prod, diff;
    int bl, k;
    angle_res_t r;
    r = '0;
    na2 = longint'(p.ax) * p.ax + longint'(p.ay) * p.ay + longint'(p.az) * p.az;
    nb2 = longint'(p.bx) * p.bx + longint'(p.by) * p.by + longint'(p.bz) * p.bz;
    d = longint'(p.ax) * p.bx + longint'(p.ay) * p.by + longint'(p.az) * p.bz;
    lim = {48'd0, mn} * {48'd0, mn};
    if (na2 < lim || nb2 < lim) begin
      r.invalid = 1'b1;
      return r;
    end
    if (na2 == 0 || nb2 == 0) return r;
    dm = d < 0 ? -d : d;
    prod = {64'd0, na2} * {64'd0, nb2};
    diff = prod - {64'd0, dm} * {64'd0, dm};
    bl = 0;
    for (int b = 127; b >= 0; b--)
      if (bl == 0 && prod[b]) bl = b + 1;
    k = (120 - bl) / 2;
    diff = diff << (2 * k);
    s = '0;
    for (int b = 59; b >= 0; b--) begin
      c = s | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= diff) s = c;
    end
    m = dm << k;
    if (d < 0) begin
      x = s; y = m; base = arctan_q60[0] << 1;
    end else begin
      x = m; y = s; base = '0;
    end
    z = '0;
    for (int i = 0; i < 60; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (!y[63]) begin
        x = x + ys; y = y - xs; z = z + arctan_q60[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_q60[i];
      end
    end
    theta = base + z;
    if (theta[63]) theta = '0;
    if (theta > (arctan_q60[0] << 2)) theta = arctan_q60[0] << 2;
    if (deg) begin
      q = (theta >> 28) * 64'd961263669;
      ang = (q + (64'd1 << 47)) >> 48;
    end else begin
      ang = (theta + (64'd1 << 45)) >> 46;
    end
    r.angle = ang > 64'hffff ? 16'hffff : ang[15:0];
    return r;
  endfunction

  task automatic add_row(input pair_t p, input logic [15:0] mn, input logic deg,
                         input bit typed, input angle_res_t res);
    row_t rw;
    rw.pair = p;
    rw.min_norm = mn;
    rw.deg = deg;
    rw.typed = typed;
    rw.res = res;
    rows.push_back(rw);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MIN_NORM) cur_min_norm = val;
    else if (idx == REG_UNIT_DEG) cur_deg = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] mn, input logic deg);
    drain();
    write_reg(REG_MIN_NORM, mn);
    write_reg(REG_UNIT_DEG, {{15{1'($urandom_range(0, 1))}}, deg});
  endtask

  task automatic send_pair(input pair_t p, input bit typed, input angle_res_t res);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z} <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    angles_due.push_back(typed ? res : predict_angle(p, cur_min_norm, cur_deg));
  endtask

  function automatic logic signed [15:0] rand_comp(input int style);
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int style, f;
    style = $urandom_range(0, 9);
    p = {rand_comp(style % 3), rand_comp(style % 3), rand_comp(style % 3),
         rand_comp(style % 3), rand_comp(style % 3), rand_comp(style % 3)};
    if (style == 7) begin
      p.bx = p.ax + 16'($urandom_range(0, 6)) - 16'sd3;
      p.by = p.ay + 16'($urandom_range(0, 6)) - 16'sd3;
      p.bz = p.az + 16'($urandom_range(0, 6)) - 16'sd3;
    end else if (style == 8) begin
      f = $urandom_range(0, 3);
      p.bx = -(p.ax >>> f);
      p.by = -(p.ay >>> f);
      p.bz = -(p.az >>> f);
    end
    return p;
  endfunction

  function automatic logic [15:0] rand_min_norm();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 12));
      3: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // result side
  always @(posedge clk) begin
    angle_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (angles_due.size() == 0) begin
        $error("unexpected beat angle=%0d invalid=%0b", out_angle, out_invalid);
        errors++;
      end else begin
        want = angles_due.pop_front();
        if (out_angle !== want.angle) begin
          $error("angle expected %0d actual %0d", want.angle, out_angle);
          errors++;
        end
        if (out_invalid !== want.invalid) begin
          $error("invalid expected %0b actual %0b", want.invalid, out_invalid);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    out_stall <= !quiet && $urandom_range(99) < 38;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    angle_res_t none, bad;
    pair_t p;
    none = '{angle: 16'd0, invalid: 1'b0};
    bad = '{angle: 16'd0, invalid: 1'b1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_NORM;
    cfg_data = '0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z} = '0;
    quiet = 1'b0;
    cur_min_norm = 16'd1;
    cur_deg = 1'b1;
    arctan_q60[0] = arctan_recip(64'd2) + arctan_recip(64'd3);
    for (int i = 1; i < 60; i++) arctan_q60[i] = arctan_recip(64'd1 << i);

    add_row({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3}, 16'd1, 1'b1, 1, bad);
    add_row({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 16'd1, 1'b1, 0, none);
    add_row({16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0}, 16'd1, 1'b1, 0, none);
    add_row({16'sd5, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 16'sd0}, 16'd1, 1'b1, 0, none);
    add_row({6{-16'sd32768}}, 16'd1, 1'b1, 0, none);
    add_row({{3{-16'sd32768}}, {3{16'sd32767}}}, 16'd1, 1'b1, 0, none);
    add_row({{3{16'sd32767}}, {3{-16'sd32768}}}, 16'd1, 1'b1, 0, none);
    add_row({16'sd3, 16'sd4, 16'sd0, 16'sd5, 16'sd0, 16'sd0}, 16'd1, 1'b1, 0, none);
    add_row({6{16'sd0}}, 16'd0, 1'b0, 1, none);
    add_row({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1}, 16'd0, 1'b0, 1, none);
    add_row({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 16'd0, 1'b0, 0, none);
    add_row({16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0}, 16'd0, 1'b0, 0, none);
    add_row({{3{16'sd32767}}, {3{-16'sd32768}}}, 16'd0, 1'b0, 0, none);
    add_row({-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1, 16'sd1}, 16'd0, 1'b0, 0, none);
    add_row({6{16'sd32767}}, 16'hffff, 1'b1, 1, bad);
    add_row({6{-16'sd32768}}, 16'hffff, 1'b1, 1, bad);
    add_row({16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 16'hffff, 1'b1, 1, bad);
    add_row({16'sd3, 16'sd4, 16'sd0, 16'sd1, 16'sd1, 16'sd1}, 16'd5, 1'b0, 1, bad);
    add_row({16'sd3, 16'sd4, 16'sd0, 16'sd0, -16'sd5, 16'sd0}, 16'd5, 1'b0, 0, none);
    add_row({16'sd3, 16'sd4, 16'sd0, -16'sd3, -16'sd4, 16'sd0}, 16'd5, 1'b1, 0, none);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].min_norm != cur_min_norm || rows[i].deg != cur_deg)
        set_config(rows[i].min_norm, rows[i].deg);
      send_pair(rows[i].pair, rows[i].typed, rows[i].res);
    end

    drain();
    write_reg(REG_UNUSED, 16'h0000);
    add_row({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0}, 16'd0, 1'b0, 0, none);
    send_pair(rows[rows.size() - 1].pair, 1'b0, none);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) set_config(16'd0, 1'b0);
      else if (ph == 1) set_config(16'hffff, 1'b1);
      else set_config(rand_min_norm(), 1'($urandom_range(0, 1)));
      quiet = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        p = rand_pair();
        send_pair(p, 1'b0, none);
      end
      quiet = 1'b0;
    end

    drain();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
